@@ hw/rtl/bba_pkg.sv @@
// shared types and constants of the bitmap block allocator
`default_nettype none

package bba_pkg;

  // fixed field widths
  localparam int unsigned LBN_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_SH = 6;

  // action codes
  localparam logic [ACT_W-1:0] ACT_TEST       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MARK_ALLOC = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MARK_FREE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ALLOC      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FORMAT     = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RAM   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FAIL  = 2'd3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RAM_WINDOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DISK_TRACKED = 2'd1;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_RESULT,
    DP_READ,
    DP_TEST,
    DP_MARK,
    DP_MOD_START,
    DP_SCAN_A,
    DP_SCAN_B,
    DP_SCAN,
    DP_CLEAR_WORD,
    DP_FMT_WORD,
    DP_FMT_END
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t            op;
    logic [STAT_W-1:0] code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             in_range;
    logic             is_ram;
    logic             free_zero;
    logic             t_zero;
    logic             mod_done;
    logic             s_zero;
    logic             hit;
    logic             phase_end;
    logic             sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bba_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bba_ctrl.sv @@
// controller state machine of the bitmap block allocator
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_TEST,
    S_MARK,
    S_MOD,
    S_SCAN_A,
    S_RUN_A,
    S_SCAN_B,
    S_RUN_B,
    S_FMT,
    S_FMT_END
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    cmd.code   = STAT_OK;
    case (state)
      S_CLEAR: begin
        cmd.op = DP_CLEAR_WORD;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (stat.act)
          ACT_TEST: begin
            if (stat.in_range && !stat.is_ram) begin
              cmd.op     = DP_READ;
              state_next = S_TEST;
            end else begin
              cmd.op   = DP_RESULT;
              cmd.code = stat.in_range ? STAT_RAM : STAT_OK;
            end
          end
          ACT_MARK_ALLOC, ACT_MARK_FREE: begin
            if (!stat.in_range) begin
              cmd.op   = DP_RESULT;
              cmd.code = STAT_RANGE;
            end else if (stat.is_ram) begin
              cmd.op   = DP_RESULT;
              cmd.code = STAT_RAM;
            end else begin
              cmd.op     = DP_READ;
              state_next = S_MARK;
            end
          end
          ACT_ALLOC: begin
            if (stat.free_zero) begin
              cmd.op   = DP_RESULT;
              cmd.code = STAT_RANGE;
            end else if (stat.t_zero) begin
              cmd.op   = DP_RESULT;
              cmd.code = STAT_FAIL;
            end else begin
              cmd.op     = DP_MOD_START;
              state_next = S_MOD;
            end
          end
          ACT_FORMAT: begin
            state_next = S_FMT;
          end
          default: begin
            cmd.op   = DP_RESULT;
            cmd.code = STAT_OK;
          end
        endcase
      end
      S_TEST: begin
        cmd.op     = DP_TEST;
        state_next = S_IDLE;
      end
      S_MARK: begin
        cmd.op     = DP_MARK;
        state_next = S_IDLE;
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_next = S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        cmd.op     = DP_SCAN_A;
        state_next = S_RUN_A;
      end
      S_RUN_A: begin
        cmd.op = DP_SCAN;
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.phase_end) begin
          if (stat.s_zero) begin
            cmd.op     = DP_RESULT;
            cmd.code   = STAT_FAIL;
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN_B;
          end
        end
      end
      S_SCAN_B: begin
        cmd.op     = DP_SCAN_B;
        state_next = S_RUN_B;
      end
      S_RUN_B: begin
        cmd.op = DP_SCAN;
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.phase_end) begin
          cmd.op     = DP_RESULT;
          cmd.code   = STAT_FAIL;
          state_next = S_IDLE;
        end
      end
      S_FMT: begin
        cmd.op = DP_FMT_WORD;
        if (stat.sweep_last) begin
          state_next = S_FMT_END;
        end
      end
      S_FMT_END: begin
        cmd.op     = DP_FMT_END;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result strobe on the way back to idle, not after the clearing pass
  assign done_next = (state != S_IDLE) && (state != S_CLEAR) && (state_next == S_IDLE);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= done_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bba_datapath.sv @@
// datapath: config, counters, bitmap ram, remainder unit and word scanner
`default_nettype none

module bba_datapath
  import bba_pkg::*;
#(
  parameter int unsigned MAP_BITS      = 32768,
  parameter int unsigned RESERVED_DISK = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic [ACT_W-1:0]     action,
  input  wire logic [LBN_W-1:0]     logical_block,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  output logic      [STAT_W-1:0]    status,
  output logic                      is_set,
  output logic      [LBN_W-1:0]     granted_block,
  output logic      [CNT_W-1:0]     free_left
);

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned MC_W      = $clog2(CNT_W + 1);
  localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [31:0]      MAP_BITS_W = 32'(MAP_BITS);
  localparam logic [CNT_W-1:0] RES_C      = CNT_W'(RESERVED_DISK);
  localparam logic [31:0]      RES_W      = 32'(RESERVED_DISK);
  localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};

  // configuration and state registers
  logic [REG_W-1:0] ram_window;
  logic [REG_W-1:0] disk_tracked;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] hint;

  // latched item
  logic [ACT_W-1:0] act;
  logic [LBN_W-1:0] lbn;

  // remainder unit
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] mq;
  logic [MC_W-1:0]  mod_cnt;
  logic [CNT_W:0]   mod_shift;
  logic [CNT_W:0]   mod_sub;

  // scanner
  logic [AW-1:0]      lw;
  logic [AW-1:0]      la;
  logic [AW-1:0]      ia;
  logic [AW-1:0]      rw;
  logic [WORD_SH-1:0] lo_off;
  logic [WORD_SH-1:0] hi_off;
  logic               issuing;
  logic               rv;
  logic [CNT_W-1:0]   scan_lo;
  logic [CNT_W-1:0]   scan_hi;
  logic [CNT_W-1:0]   hi_m1;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  cand;
  logic [WORD_SH-1:0] hit_bit;
  logic               hit;
  logic [CNT_W-1:0]   hit_entry;

  // sweep counter
  logic [AW-1:0]     sw;
  logic [31:0]       sw_base;
  logic [31:0]       r_w;
  logic [WORD_W-1:0] res_mask;

  // decode of the item
  logic [CNT_W-1:0]   t;
  logic [CNT_W-1:0]   r;
  logic [CNT_W:0]     user_total;
  logic               in_range;
  logic               is_ram;
  logic [31:0]        entry_w;
  logic [CNT_W-1:0]   entry;
  logic [AW-1:0]      entry_addr;
  logic [WORD_SH-1:0] entry_bit;
  logic               cur_bit;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] rd_data;

  // tracked range, reserved part and user range
  always_comb begin
    t = (32'(disk_tracked) > MAP_BITS_W) ? CNT_W'(MAP_BITS) : disk_tracked;
    r = (t < RES_C) ? t : RES_C;
    user_total = {1'b0, ram_window} + ((t > RES_C) ? {1'b0, t - RES_C} : '0);
    in_range   = 32'(user_total) > lbn;
    is_ram     = 32'(ram_window) > lbn;
    entry_w    = lbn - 32'(ram_window) + RES_W;
    entry      = entry_w[CNT_W-1:0];
    entry_addr = AW'(entry >> WORD_SH);
    entry_bit  = entry[WORD_SH-1:0];
    cur_bit    = rd_data[entry_bit];
  end

  // remainder step: one quotient bit a cycle
  assign mod_shift = {rem, mq[CNT_W-1]};
  assign mod_sub   = mod_shift - {1'b0, t};

  // bounds of the scan phase being loaded
  always_comb begin
    if (cmd.op == DP_SCAN_B) begin
      scan_lo = '0;
      scan_hi = rem;
    end else begin
      scan_lo = rem;
      scan_hi = t;
    end
    hi_m1 = scan_hi - 1'b1;
  end

  // first clear bit inside the phase bounds of the word just read
  always_comb begin
    lo_mask = (rw == lw) ? (ONES << lo_off) : ONES;
    hi_mask = (rw == la) ? (ONES >> (WORD_SH'(WORD_W - 1) - hi_off)) : ONES;
    cand    = ~rd_data & lo_mask & hi_mask;
    hit_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_bit = WORD_SH'(j);
      end
    end
    hit       = rv && (cand != '0);
    hit_entry = (CNT_W'(rw) << WORD_SH) | CNT_W'(hit_bit);
  end

  // reserved bits of the word under the sweep counter
  always_comb begin
    sw_base = 32'(sw) << WORD_SH;
    r_w     = 32'(r);
    if (r_w >= sw_base + WORD_W) begin
      res_mask = ONES;
    end else if (r_w <= sw_base) begin
      res_mask = '0;
    end else begin
      res_mask = ~(ONES << WORD_SH'(r_w - sw_base));
    end
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_addr;
    ram_wdata = rd_data;
    ram_raddr = (cmd.op == DP_READ) ? entry_addr : ia;
    case (cmd.op)
      DP_MARK: begin
        ram_waddr = entry_addr;
        if (act == ACT_MARK_ALLOC) begin
          ram_we    = !cur_bit;
          ram_wdata = rd_data | (WORD_W'(1) << entry_bit);
        end else begin
          ram_we    = cur_bit;
          ram_wdata = rd_data & ~(WORD_W'(1) << entry_bit);
        end
      end
      DP_SCAN: begin
        ram_we    = hit;
        ram_waddr = rw;
        ram_wdata = rd_data | (WORD_W'(1) << hit_bit);
      end
      DP_CLEAR_WORD: begin
        ram_we    = 1'b1;
        ram_waddr = sw;
        ram_wdata = '0;
      end
      DP_FMT_WORD: begin
        ram_we    = 1'b1;
        ram_waddr = sw;
        ram_wdata = res_mask;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_window   <= 16'd992;
      disk_tracked <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_WINDOW:   ram_window   <= cfg_data;
        REG_DISK_TRACKED: disk_tracked <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // control registers: counters, hint, scanner and remainder sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      hint       <= '0;
      mod_cnt    <= '0;
      issuing    <= 1'b0;
      rv         <= 1'b0;
      sw         <= '0;
    end else begin
      // remainder unit runs on its own once started
      if (cmd.op == DP_MOD_START) begin
        mod_cnt <= MC_W'(CNT_W);
      end else if (mod_cnt != '0) begin
        mod_cnt <= mod_cnt - 1'b1;
      end

      // read pipeline of the scanner
      rv <= (cmd.op == DP_SCAN) && issuing;
      case (cmd.op)
        DP_SCAN_A, DP_SCAN_B: begin
          issuing <= 1'b1;
        end
        DP_SCAN: begin
          if (issuing && (ia == la)) begin
            issuing <= 1'b0;
          end
        end
        default: begin
          issuing <= 1'b0;
        end
      endcase

      case (cmd.op)
        DP_MARK: begin
          if (act == ACT_MARK_ALLOC) begin
            if (!cur_bit && (free_count != '0)) begin
              free_count <= free_count - 1'b1;
            end
          end else if (cur_bit) begin
            if (free_count != {CNT_W{1'b1}}) begin
              free_count <= free_count + 1'b1;
            end
            if (entry < hint) begin
              hint <= entry;
            end
          end
        end
        DP_SCAN: begin
          if (hit) begin
            free_count <= free_count - 1'b1;
            hint       <= hit_entry + 1'b1;
          end
        end
        DP_CLEAR_WORD, DP_FMT_WORD: begin
          sw <= (sw == LAST_WORD) ? '0 : sw + 1'b1;
        end
        DP_FMT_END: begin
          free_count <= t - r;
          hint       <= r;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers: item, remainder, scan bounds and result
  always_ff @(posedge clk) begin
    if (cmd.op == DP_MOD_START) begin
      rem <= '0;
      mq  <= hint;
    end else if (mod_cnt != '0) begin
      rem <= (mod_shift >= {1'b0, t}) ? mod_sub[CNT_W-1:0] : mod_shift[CNT_W-1:0];
      mq  <= mq << 1;
    end

    case (cmd.op)
      DP_LOAD: begin
        act <= action;
        lbn <= logical_block;
      end
      DP_RESULT: begin
        status        <= cmd.code;
        is_set        <= 1'b0;
        granted_block <= '0;
      end
      DP_TEST: begin
        status        <= STAT_OK;
        is_set        <= cur_bit;
        granted_block <= '0;
      end
      DP_MARK, DP_FMT_END: begin
        status        <= STAT_OK;
        is_set        <= 1'b0;
        granted_block <= '0;
      end
      DP_SCAN_A, DP_SCAN_B: begin
        lw     <= AW'(scan_lo >> WORD_SH);
        ia     <= AW'(scan_lo >> WORD_SH);
        lo_off <= scan_lo[WORD_SH-1:0];
        la     <= AW'(hi_m1 >> WORD_SH);
        hi_off <= hi_m1[WORD_SH-1:0];
      end
      DP_SCAN: begin
        rw <= ia;
        if (issuing) begin
          ia <= ia + 1'b1;
        end
        if (hit) begin
          is_set <= 1'b0;
          if (hit_entry < RES_C) begin
            status        <= STAT_FAIL;
            granted_block <= '0;
          end else begin
            status        <= STAT_OK;
            granted_block <= 32'(ram_window) + 32'(hit_entry) - RES_W;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    stat.act        = act;
    stat.in_range   = in_range;
    stat.is_ram     = is_ram;
    stat.free_zero  = (free_count == '0);
    stat.t_zero     = (t == '0);
    stat.mod_done   = (mod_cnt == '0);
    stat.s_zero     = (rem == '0);
    stat.hit        = hit;
    stat.phase_end  = rv && (rw == la) && !hit;
    stat.sweep_last = (sw == LAST_WORD);
  end

  assign free_left = free_count;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_block_allocator.sv @@
// top level of the bitmap block allocator
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------
//   item in   | start, busy            | action, logical_block
//   result    | done (one-cycle strobe)| status, is_set, granted_block, free_left
//   config    | cfg_we                 | cfg_index, cfg_data
//
// test and mark latch the item, decide, read its map word, then test or mark it; other
// early answers are given from the decide state. allocate takes the hint modulo the tracked
// count, then reads 64-bit map words (one a cycle from the ram read port) from there to the
// tracked end and, when the search wraps to the map start, from word 0; up to MAP_BITS/64 + 1
// words in all. format writes one map word a cycle; after reset a clearing pass holds busy
// high. the receiver cannot stall: each result is held until the next item writes its own.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAP_BITS      = 32768,
  parameter int unsigned RESERVED_DISK = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ACT_W-1:0]     action,
  input  wire logic [LBN_W-1:0]     logical_block,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  output logic                      done,
  output logic      [STAT_W-1:0]    status,
  output logic                      is_set,
  output logic      [LBN_W-1:0]     granted_block,
  output logic      [CNT_W-1:0]     free_left
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bba_datapath #(
    .MAP_BITS      (MAP_BITS),
    .RESERVED_DISK (RESERVED_DISK)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .logical_block (logical_block),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .is_set        (is_set),
    .granted_block (granted_block),
    .free_left     (free_left)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bba_checker.sv @@
// port level checks of the bitmap block allocator, bound to the top level
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [STAT_W-1:0] status,
  input wire logic              is_set,
  input wire logic [LBN_W-1:0]  granted_block
);

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // a result follows a busy cycle and shows while idle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of an item");

  // no grant on a failed item
  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (granted_block == '0))
    else $error("granted block with an error status");

  // a set test answer carries no grant
  a_test_alone: assert property (@(posedge clk) disable iff (rst)
    (done && is_set) |-> ((status == STAT_OK) && (granted_block == '0)))
    else $error("test answer mixed with other results");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .is_set        (is_set),
  .granted_block (granted_block)
);

`default_nettype wire
